[rtl/svsd_pkg.sv]
// Shared types, codes and constants for the sparse vector store and dot unit.
package svsd_pkg;

  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned INDEX_BITS_DEF = 16;
  localparam int unsigned DIM_W          = 17;
  localparam int unsigned VAL_W          = 24;
  localparam int unsigned DOT_W          = 64;
  localparam int unsigned COS_W          = 16;
  localparam logic [DIM_W-1:0] DIM_RESET = 17'h10000;

  typedef enum logic [1:0] {
    ACT_SET = 2'd0,
    ACT_GET = 2'd1,
    ACT_DOT = 2'd2,
    ACT_COS = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_MISMATCH = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_DIM_A = 1'b0,
    REG_DIM_B = 1'b1
  } reg_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_UPD,
    S_DOT_RD,
    S_DOT_CMP,
    S_MUL,
    S_ACC,
    S_NRM_RD,
    S_NRM_MUL,
    S_NRM_ACC,
    S_SQRT,
    S_DEN_MUL,
    S_DIV,
    S_DONE
  } state_e;

  // memory port request from the controller to one vector store
  typedef struct packed {
    logic        we;
    logic [7:0]  waddr;
    logic [15:0] widx;
    logic [23:0] wval;
    logic [7:0]  raddr;
  } mem_req_t;

endpackage

[rtl/sparse_vector_store_dot_unit.sv]
// Top level: sparse vector pair with set, get, dot product and cosine similarity.
//
// Items enter on start_i with action_i, which_vector_i, index_i and value_i,
// taken when start_i is high and busy_o is low. Each item gives exactly one
// result, shown for one cycle with done_o high on status_o, read_value_o,
// dot_value_o, cosine_o and entry_count_o. The receiver cannot stall.
// Both vectors live in synchronous memories (one per vector, index and value
// side by side) with one read per cycle, which paces search, shift and merge:
//   get: a binary search, each probe a read then a compare.
//   set: the search, then a read and a write per shifted entry.
//   dot: a merge step that skips an entry is a read and a compare; one for a
//        matching index is a read, a compare with multiply and an accumulate;
//        at most 2*CAPACITY steps.
//   cosine: the dot, two norm passes (read, multiply, accumulate per entry),
//        two 32-step square roots, a 32x32 multiply and a 15-step divide.
// The dim_a and dim_b registers sit on the APB port at byte addresses 0 and 4
// and reset to 65536. Reset empties both vectors (counts go to zero); the
// memories themselves are not cleared.
module sparse_vector_store_dot_unit #(
  parameter int unsigned CAPACITY   = svsd_pkg::CAPACITY_DEF,
  parameter int unsigned INDEX_BITS = svsd_pkg::INDEX_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic        which_vector_i,
  input  logic [15:0] index_i,
  input  logic signed [23:0] value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic signed [23:0] read_value_o,
  output logic signed [63:0] dot_value_o,
  output logic signed [15:0] cosine_o,
  output logic [8:0]  entry_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  // configuration
  logic [16:0] dim_a_q, dim_b_q;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_a_q <= svsd_pkg::DIM_RESET;
      dim_b_q <= svsd_pkg::DIM_RESET;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == svsd_pkg::REG_DIM_A) begin
        dim_a_q <= pwdata[16:0];
      end else begin
        dim_b_q <= pwdata[16:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == svsd_pkg::REG_DIM_A) begin
      prdata[16:0] = dim_a_q;
    end else begin
      prdata[16:0] = dim_b_q;
    end
  end

  // memories
  logic                  we_a, we_b;
  logic [AW-1:0]         waddr, raddr_a, raddr_b;
  logic [INDEX_BITS-1:0] widx, ridx_a, ridx_b;
  logic [23:0]           wval, rval_a, rval_b;

  svsd_store #(.CAPACITY(CAPACITY), .INDEX_BITS(INDEX_BITS)) u_store_a (
    .clk_i, .we_i(we_a), .waddr_i(waddr), .widx_i(widx), .wval_i(wval),
    .raddr_i(raddr_a), .ridx_o(ridx_a), .rval_o(rval_a)
  );
  svsd_store #(.CAPACITY(CAPACITY), .INDEX_BITS(INDEX_BITS)) u_store_b (
    .clk_i, .we_i(we_b), .waddr_i(waddr), .widx_i(widx), .wval_i(wval),
    .raddr_i(raddr_b), .ridx_o(ridx_b), .rval_o(rval_b)
  );

  // square root unit
  logic        sq_start, sq_done;
  logic [63:0] sq_x;
  logic [31:0] sq_root;
  svsd_isqrt u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .x_i(sq_x), .done_o(sq_done), .root_o(sq_root)
  );

  // controller state
  svsd_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [1:0]  act_q, act_d;
  logic        sel_q, sel_d;
  logic [INDEX_BITS-1:0] key_q, key_d;
  logic signed [23:0] val_q, val_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d;
  logic        found_q, found_d;
  logic signed [47:0] prod_q, prod_d;
  logic signed [63:0] acc_q, acc_d;
  logic [63:0] nsum_q, nsum_d;
  logic        nb_q, nb_d;
  logic [31:0] na_q, na_d;
  logic [63:0] den_q, den_d, rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [3:0]  k_q, k_d;
  logic [1:0]  st_q, st_d;
  logic signed [23:0] rd_q, rd_d;
  logic signed [15:0] cos_q, cos_d;
  logic        done_q, done_d;

  logic [CW-1:0] cnt_sel, mid, lo_p1;
  logic [16:0]   dim_sel;
  logic [INDEX_BITS-1:0] ridx_sel;
  logic [23:0]   rval_sel;
  logic [63:0]   mag, rem_sh;
  logic [CW:0]   midsum;

  assign cnt_sel  = sel_q ? cnt_b_q : cnt_a_q;
  assign dim_sel  = sel_q ? dim_b_q : dim_a_q;
  assign ridx_sel = sel_q ? ridx_b : ridx_a;
  assign rval_sel = sel_q ? rval_b : rval_a;
  assign midsum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = midsum[CW:1];
  assign lo_p1    = mid + CW'(1);
  assign mag      = acc_q[63] ? (64'd0 - acc_q) : acc_q;
  assign rem_sh   = {rem_q[62:0], 1'b0};

  always_comb begin
    state_d = state_q;
    cnt_a_d = cnt_a_q; cnt_b_d = cnt_b_q;
    act_d = act_q; sel_d = sel_q; key_d = key_q; val_d = val_q;
    lo_d = lo_q; hi_d = hi_q; i_d = i_q; j_d = j_q; found_d = found_q;
    prod_d = prod_q; acc_d = acc_q; nsum_d = nsum_q; nb_d = nb_q; na_d = na_q;
    den_d = den_q; rem_d = rem_q; quo_d = quo_q; k_d = k_q;
    st_d = st_q; rd_d = rd_q; cos_d = cos_q;
    done_d = 1'b0;
    we_a = 1'b0; we_b = 1'b0;
    waddr = '0; widx = key_q; wval = val_q;
    raddr_a = i_q[AW-1:0]; raddr_b = j_q[AW-1:0];
    sq_start = 1'b0; sq_x = nsum_q;
    busy_o = (state_q != svsd_pkg::S_IDLE);

    case (state_q)
      svsd_pkg::S_IDLE: begin
        if (start_i) begin
          act_d = action_i; sel_d = which_vector_i;
          key_d = index_i[INDEX_BITS-1:0]; val_d = value_i;
          lo_d = '0; hi_d = which_vector_i ? cnt_b_q : cnt_a_q;
          i_d = '0; j_d = '0; found_d = 1'b0;
          acc_d = '0; nsum_d = '0; nb_d = 1'b0;
          st_d = svsd_pkg::ST_OK; rd_d = '0; cos_d = '0;
          if (action_i == svsd_pkg::ACT_SET || action_i == svsd_pkg::ACT_GET) begin
            state_d = svsd_pkg::S_SRCH_RD;
          end else begin
            state_d = svsd_pkg::S_DOT_RD;
          end
        end
      end
      svsd_pkg::S_SRCH_RD: begin
        if ({{(17-INDEX_BITS){1'b0}}, key_q} >= dim_sel) begin
          st_d = svsd_pkg::ST_RANGE;
          state_d = svsd_pkg::S_DONE;
        end else if (lo_q >= hi_q) begin
          state_d = svsd_pkg::S_UPD;
        end else begin
          raddr_a = mid[AW-1:0]; raddr_b = mid[AW-1:0];
          state_d = svsd_pkg::S_SRCH_CMP;
        end
      end
      svsd_pkg::S_SRCH_CMP: begin
        if (ridx_sel == key_q) begin
          found_d = 1'b1; lo_d = mid; rd_d = rval_sel;
          state_d = svsd_pkg::S_UPD;
        end else begin
          if (ridx_sel < key_q) lo_d = lo_p1;
          else hi_d = mid;
          state_d = svsd_pkg::S_SRCH_RD;
        end
      end
      svsd_pkg::S_UPD: begin
        // lo_q holds the hit or insert position
        if (act_q == svsd_pkg::ACT_GET) begin
          if (!found_q) rd_d = '0;
          state_d = svsd_pkg::S_DONE;
        end else begin
          rd_d = '0;
          if (found_q && val_q != 24'sd0) begin
            waddr = lo_q[AW-1:0];
            we_a = !sel_q; we_b = sel_q;
            state_d = svsd_pkg::S_DONE;
          end else if (found_q) begin
            // delete: pull entries down from lo+1
            i_d = lo_q + CW'(1);
            state_d = svsd_pkg::S_SHIFT_RD;
          end else if (val_q == 24'sd0) begin
            state_d = svsd_pkg::S_DONE;
          end else if (cnt_sel >= CAP) begin
            st_d = svsd_pkg::ST_FULL;
            state_d = svsd_pkg::S_DONE;
          end else begin
            // insert: push entries up from the top
            i_d = cnt_sel;
            state_d = svsd_pkg::S_SHIFT_RD;
          end
        end
      end
      svsd_pkg::S_SHIFT_RD: begin
        if (found_q) begin
          if (i_q >= cnt_sel) begin
            if (sel_q) cnt_b_d = cnt_b_q - CW'(1);
            else cnt_a_d = cnt_a_q - CW'(1);
            state_d = svsd_pkg::S_DONE;
          end else begin
            raddr_a = i_q[AW-1:0]; raddr_b = i_q[AW-1:0];
            state_d = svsd_pkg::S_SHIFT_WR;
          end
        end else begin
          if (i_q <= lo_q) begin
            waddr = lo_q[AW-1:0];
            we_a = !sel_q; we_b = sel_q;
            if (sel_q) cnt_b_d = cnt_b_q + CW'(1);
            else cnt_a_d = cnt_a_q + CW'(1);
            state_d = svsd_pkg::S_DONE;
          end else begin
            raddr_a = AW'(i_q - CW'(1)); raddr_b = AW'(i_q - CW'(1));
            state_d = svsd_pkg::S_SHIFT_WR;
          end
        end
      end
      svsd_pkg::S_SHIFT_WR: begin
        widx = ridx_sel; wval = rval_sel;
        we_a = !sel_q; we_b = sel_q;
        if (found_q) begin
          waddr = AW'(i_q - CW'(1));
          i_d = i_q + CW'(1);
        end else begin
          waddr = i_q[AW-1:0];
          i_d = i_q - CW'(1);
        end
        state_d = svsd_pkg::S_SHIFT_RD;
      end
      svsd_pkg::S_DOT_RD: begin
        if (dim_a_q != dim_b_q) begin
          st_d = svsd_pkg::ST_MISMATCH;
          acc_d = '0;
          state_d = svsd_pkg::S_DONE;
        end else if (i_q >= cnt_a_q || j_q >= cnt_b_q) begin
          if (act_q == svsd_pkg::ACT_COS && acc_q != 64'sd0) begin
            i_d = '0;
            state_d = svsd_pkg::S_NRM_RD;
          end else begin
            state_d = svsd_pkg::S_DONE;
          end
        end else begin
          state_d = svsd_pkg::S_DOT_CMP;
        end
      end
      svsd_pkg::S_DOT_CMP: begin
        if (ridx_a < ridx_b) begin
          i_d = i_q + CW'(1);
          state_d = svsd_pkg::S_DOT_RD;
        end else if (ridx_a > ridx_b) begin
          j_d = j_q + CW'(1);
          state_d = svsd_pkg::S_DOT_RD;
        end else begin
          prod_d = $signed(rval_a) * $signed(rval_b);
          state_d = svsd_pkg::S_ACC;
        end
      end
      svsd_pkg::S_ACC: begin
        acc_d = acc_q + 64'(prod_q);
        i_d = i_q + CW'(1); j_d = j_q + CW'(1);
        state_d = svsd_pkg::S_DOT_RD;
      end
      svsd_pkg::S_NRM_RD: begin
        if (i_q >= (nb_q ? cnt_b_q : cnt_a_q)) begin
          sq_start = 1'b1;
          state_d = svsd_pkg::S_SQRT;
        end else begin
          raddr_a = i_q[AW-1:0]; raddr_b = i_q[AW-1:0];
          state_d = svsd_pkg::S_NRM_MUL;
        end
      end
      svsd_pkg::S_NRM_MUL: begin
        prod_d = nb_q ? $signed(rval_b) * $signed(rval_b)
                      : $signed(rval_a) * $signed(rval_a);
        state_d = svsd_pkg::S_NRM_ACC;
      end
      svsd_pkg::S_NRM_ACC: begin
        nsum_d = nsum_q + 64'(prod_q);
        i_d = i_q + CW'(1);
        state_d = svsd_pkg::S_NRM_RD;
      end
      svsd_pkg::S_SQRT: begin
        if (sq_done) begin
          if (!nb_q) begin
            na_d = sq_root; nb_d = 1'b1; nsum_d = '0; i_d = '0;
            state_d = svsd_pkg::S_NRM_RD;
          end else begin
            state_d = svsd_pkg::S_DEN_MUL;
          end
        end
      end
      svsd_pkg::S_DEN_MUL: begin
        den_d = 64'(na_q) * 64'(sq_root);
        rem_d = mag; quo_d = '0; k_d = '0;
        if (na_q == 32'd0 || sq_root == 32'd0) state_d = svsd_pkg::S_DONE;
        else state_d = svsd_pkg::S_DIV;
      end
      svsd_pkg::S_DIV: begin
        if (k_q == 4'd0 && rem_q >= den_q) begin
          quo_d = 16'h8000;
          k_d = 4'd15;
        end else if (k_q == 4'd15) begin
          if (acc_q[63]) cos_d = 16'sd0 - $signed(quo_q);
          else cos_d = quo_q[15] ? 16'sh7fff : $signed(quo_q);
          state_d = svsd_pkg::S_DONE;
        end else begin
          // rem < den < 2^64 so shifted value fits in 65 bits
          if ({rem_q[63], rem_sh} >= {1'b0, den_q}) begin
            rem_d = rem_sh - den_q; quo_d = {quo_q[14:0], 1'b1};
          end else begin
            rem_d = rem_sh; quo_d = {quo_q[14:0], 1'b0};
          end
          k_d = k_q + 4'd1;
        end
      end
      svsd_pkg::S_DONE: begin
        done_d = 1'b1;
        state_d = svsd_pkg::S_IDLE;
      end
      default: state_d = svsd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svsd_pkg::S_IDLE;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; sel_q <= sel_d; key_q <= key_d; val_q <= val_d;
    lo_q <= lo_d; hi_q <= hi_d; i_q <= i_d; j_q <= j_d; found_q <= found_d;
    prod_q <= prod_d; acc_q <= acc_d; nsum_q <= nsum_d; nb_q <= nb_d; na_q <= na_d;
    den_q <= den_d; rem_q <= rem_d; quo_q <= quo_d; k_q <= k_d;
    st_q <= st_d; rd_q <= rd_d; cos_q <= cos_d;
  end

  assign done_o        = done_q;
  assign status_o      = st_q;
  assign read_value_o  = rd_q;
  assign dot_value_o   = (act_q[1]) ? acc_q : 64'sd0;
  assign cosine_o      = cos_q;
  assign entry_count_o = 9'(cnt_sel);

  // counts never exceed capacity
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_a_q <= CAP && cnt_b_q <= CAP) else $error("count above capacity");
  // a result follows only from a finishing step
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == svsd_pkg::S_DONE) else $error("stray result");
  // the controller is idle while a result is shown
  a_idle_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == svsd_pkg::S_IDLE) else $error("result while busy");
  // the count of vector a changes only right after a shift-read step
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && cnt_a_q != $past(cnt_a_q) |-> $past(state_q) == svsd_pkg::S_SHIFT_RD)
    else $error("count changed outside update");

endmodule

[rtl/svsd_store.sv]
// One sparse vector store: index and value memories with a registered read port.
module svsd_store #(
  parameter int unsigned CAPACITY   = svsd_pkg::CAPACITY_DEF,
  parameter int unsigned INDEX_BITS = svsd_pkg::INDEX_BITS_DEF,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [INDEX_BITS-1:0]       widx_i,
  input  logic [svsd_pkg::VAL_W-1:0]  wval_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [INDEX_BITS-1:0]       ridx_o,
  output logic [svsd_pkg::VAL_W-1:0]  rval_o
);

  logic [INDEX_BITS+svsd_pkg::VAL_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {widx_i, wval_i};
    end
    {ridx_o, rval_o} <= mem[raddr_i];
  end

endmodule

[rtl/svsd_isqrt.sv]
// Iterative 64-bit integer square root, one result bit per cycle.
module svsd_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] x_q, x_d, r_q, r_d, bit_q, bit_d;
  logic        run_q, run_d;
  logic [64:0] trial;

  always_comb begin
    x_d    = x_q;
    r_d    = r_q;
    bit_d  = bit_q;
    run_d  = run_q;
    done_o = 1'b0;
    trial  = {1'b0, r_q} + {1'b0, bit_q};
    if (start_i) begin
      x_d   = x_i;
      r_d   = '0;
      bit_d = 64'h4000_0000_0000_0000;
      run_d = 1'b1;
    end else if (run_q) begin
      if ({1'b0, x_q} >= trial) begin
        x_d = x_q - trial[63:0];
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == 64'd1) begin
        run_d = 1'b0;
      end
    end else begin
      done_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign root_o = r_q[31:0];

endmodule
